// ----- rtl/line_pixel_stepper_assert.svh -----
// Assertion macros shared by the line stepper RTL.
`ifndef LINE_PIXEL_STEPPER_ASSERT_SVH
`define LINE_PIXEL_STEPPER_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define LPS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define LPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/lps_pkg.sv -----
`timescale 1ns / 1ps

package lps_pkg;

  // Fixed field and state widths
  localparam int POS_W      = 32;
  localparam int PIX_W      = 12;
  localparam int CFG_W      = 13;
  localparam int STEP_W     = 16;
  localparam int CFG_IDX_W  = 1;
  // Fractional bits of the computed line length
  localparam int LEN_FRAC   = 14;

  // Request kinds
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_W = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_H = 1'b1;

  // Reset values of the screen bounds
  localparam logic [CFG_W-1:0] SCREEN_W_RST = 13'd640;
  localparam logic [CFG_W-1:0] SCREEN_H_RST = 13'd480;

  typedef enum logic [1:0] {
    ST_LOADED = 2'd0,
    ST_PIXEL  = 2'd1,
    ST_IDLE   = 2'd2
  } lps_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQX,
    S_SQY,
    S_ROOT,
    S_DIV_INIT,
    S_DIV,
    S_DONE
  } lps_state_e;

  // Solver status seen by the top level
  typedef struct packed {
    logic busy;
    logic done;
  } lps_stat_t;

endpackage

// ----- rtl/lps_solver.sv -----
`timescale 1ns / 1ps

module lps_solver #(
  parameter int COORD_BITS = 14,
  parameter int FRAC_BITS  = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [COORD_BITS:0]        dx_i,
  input  logic signed [COORD_BITS:0]        dy_i,
  output logic [lps_pkg::STEP_W-1:0]        steps_o,
  output logic signed [FRAC_BITS+1:0]       inc_x_o,
  output logic signed [FRAC_BITS+1:0]       inc_y_o,
  output lps_pkg::lps_stat_t                stat_o
);
  import lps_pkg::*;

  localparam int AW     = COORD_BITS;
  localparam int L2W    = 2 * COORD_BITS + 2;
  localparam int INT_IT = COORD_BITS + 1;
  localparam int RW     = INT_IT + LEN_FRAC;
  localparam int SW     = RW + 2;
  localparam int QB     = FRAC_BITS + 1;
  localparam int DIVW   = COORD_BITS + FRAC_BITS + LEN_FRAC + 1;
  localparam int IW     = FRAC_BITS + 2;
  localparam int ITW    = (RW > QB) ? RW : QB;
  localparam int CW     = $clog2(ITW);

  lps_state_e           state_q, state_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 sel_q, sel_d;

  logic [AW-1:0]        ax_q, ay_q;
  logic                 negx_q, negy_q;
  logic [L2W-1:0]       rad_q;
  logic [RW-1:0]        root_q;
  logic [SW-1:0]        rem_q;
  logic [QB-1:0]        qsh_q;
  logic [STEP_W-1:0]    steps_q;
  logic signed [IW-1:0] incx_q, incy_q;

  logic [AW-1:0]        mul_a;
  logic [2*AW-1:0]      prod;
  logic [SW-1:0]        sub_a, sub_b, sub_diff, rem_nxt;
  logic [SW:0]          sub_ext;
  logic                 sub_ge;
  logic [RW-1:0]        root_nxt;
  logic [QB-1:0]        qsh_nxt;
  logic [INT_IT:0]      nsum;
  logic [31:0]          nsum_w;
  logic [STEP_W-1:0]    steps_sat;
  logic [DIVW-1:0]      div_dvd;
  logic signed [IW-1:0] inc_val;
  logic                 last_root, last_div, int_done;

  // Square the axis differences with one shared multiplier
  assign mul_a = (state_q == S_SQY) ? ay_q : ax_q;
  assign prod  = mul_a * mul_a;

  // Shared compare-subtract unit: root digits, then quotient bits
  always_comb begin
    case (state_q)
      S_ROOT: begin
        sub_a = {rem_q[RW-1:0], rad_q[L2W-1 -: 2]};
        sub_b = {root_q, 2'b01};
      end
      default: begin
        sub_a = {rem_q[RW:0], qsh_q[QB-1]};
        sub_b = SW'(root_q);
      end
    endcase
  end

  assign sub_ext  = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge   = ~sub_ext[SW];
  assign sub_diff = sub_ext[SW-1:0];
  assign rem_nxt  = sub_ge ? sub_diff : sub_a;
  assign root_nxt = {root_q[RW-2:0], sub_ge};
  assign qsh_nxt  = {qsh_q[QB-2:0], sub_ge};

  assign last_root = (cnt_q == CW'(RW - 1));
  assign last_div  = (cnt_q == CW'(QB - 1));
  assign int_done  = (cnt_q == CW'(INT_IT - 1));

  // Round the integer root up when a remainder is left, saturate the count
  assign nsum      = (INT_IT + 1)'(root_nxt[INT_IT-1:0]) + (INT_IT + 1)'(rem_nxt != '0);
  assign nsum_w    = 32'(nsum);
  assign steps_sat = (nsum_w > 32'hFFFF) ? '1 : nsum_w[STEP_W-1:0];

  // Dividend of the rounded division: |d| scaled plus half the length
  assign div_dvd = (DIVW'(sel_q ? ay_q : ax_q) << (FRAC_BITS + LEN_FRAC))
                 + DIVW'(root_q >> 1);

  // Apply the sign of the axis difference; a zero length gives no step
  always_comb begin
    if (root_q == '0) begin
      inc_val = '0;
    end else if (sel_q ? negy_q : negx_q) begin
      inc_val = -IW'(qsh_nxt);
    end else begin
      inc_val = IW'(qsh_nxt);
    end
  end

  // Sequence the load computation
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    sel_d   = sel_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_SQX;
        end
      end
      S_SQX: state_d = S_SQY;
      S_SQY: begin
        state_d = S_ROOT;
        cnt_d   = '0;
      end
      S_ROOT: begin
        cnt_d = cnt_q + 1'b1;
        if (last_root) begin
          state_d = S_DIV_INIT;
          sel_d   = 1'b0;
        end
      end
      S_DIV_INIT: begin
        state_d = S_DIV;
        cnt_d   = '0;
      end
      S_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (last_div) begin
          if (sel_q) begin
            state_d = S_DONE;
          end else begin
            state_d = S_DIV_INIT;
            sel_d   = 1'b1;
          end
        end
      end
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Decode status from the state
  always_comb begin
    stat_o.busy = (state_q != S_IDLE);
    stat_o.done = (state_q == S_DONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      sel_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      sel_q   <= sel_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          ax_q   <= dx_i[COORD_BITS] ? AW'(-dx_i) : AW'(dx_i);
          ay_q   <= dy_i[COORD_BITS] ? AW'(-dy_i) : AW'(dy_i);
          negx_q <= dx_i[COORD_BITS];
          negy_q <= dy_i[COORD_BITS];
        end
      end
      S_SQX: rad_q <= L2W'(prod);
      S_SQY: begin
        rad_q  <= rad_q + L2W'(prod);
        root_q <= '0;
        rem_q  <= '0;
      end
      S_ROOT: begin
        rad_q  <= rad_q << 2;
        root_q <= root_nxt;
        rem_q  <= rem_nxt;
        if (int_done) begin
          steps_q <= steps_sat;
        end
      end
      S_DIV_INIT: begin
        rem_q <= SW'(div_dvd >> QB);
        qsh_q <= div_dvd[QB-1:0];
      end
      S_DIV: begin
        rem_q <= rem_nxt;
        qsh_q <= qsh_nxt;
        if (last_div) begin
          if (sel_q) begin
            incy_q <= inc_val;
          end else begin
            incx_q <= inc_val;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign steps_o = steps_q;
  assign inc_x_o = incx_q;
  assign inc_y_o = incy_q;

endmodule

// ----- rtl/line_pixel_stepper.sv -----
`timescale 1ns / 1ps
// Channel   Dir  Ports                                         Handshake
// request   in   action_i start_x_i start_y_i end_x_i end_y_i  start & !busy
// result    out  status_o pixel_x_o pixel_y_o plotted_o last_o strobe_o, one cycle
// config    in   cfg_idx_i cfg_wdata_i                         cfg_we_i
//
// A step request is taken in any cycle with busy low; its result strobes the next cycle.
// A load holds busy while the shared compare-subtract unit forms the root and both quotients
// one bit per cycle; its result strobes in the first cycle with busy low again.
// Reset leaves no active line and the screen at 640 by 480.
// Results cannot be stalled: each is shown for exactly one cycle.
`include "line_pixel_stepper_assert.svh"

module line_pixel_stepper #(
  parameter int COORD_BITS = 14,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                action_i,
  input  logic signed [COORD_BITS-1:0]        start_x_i,
  input  logic signed [COORD_BITS-1:0]        start_y_i,
  input  logic signed [COORD_BITS-1:0]        end_x_i,
  input  logic signed [COORD_BITS-1:0]        end_y_i,
  output logic                                strobe_o,
  output logic [1:0]                          status_o,
  output logic [lps_pkg::PIX_W-1:0]           pixel_x_o,
  output logic [lps_pkg::PIX_W-1:0]           pixel_y_o,
  output logic                                plotted_o,
  output logic                                last_o,
  input  logic                                cfg_we_i,
  input  logic [lps_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [lps_pkg::CFG_W-1:0]           cfg_wdata_i
);
  import lps_pkg::*;

  localparam int IW = FRAC_BITS + 2;

  logic [CFG_W-1:0]     scr_w_q, scr_h_q;
  logic [POS_W-1:0]     pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic signed [IW-1:0] inc_x_q, inc_x_d, inc_y_q, inc_y_d;
  logic [STEP_W-1:0]    steps_q, steps_d;

  logic                 strobe_q, strobe_d;
  lps_status_e          status_q, status_d;
  logic [PIX_W-1:0]     pix_x_q, pix_x_d, pix_y_q, pix_y_d;
  logic                 plotted_q, plotted_d;
  logic                 last_q, last_d;

  logic                 accept, load_acc, step_acc, line_active;
  logic signed [COORD_BITS:0] dx, dy;
  logic [POS_W-1:0]     ipx, ipy;
  logic                 okx, oky;

  lps_stat_t            sol_stat;
  logic [STEP_W-1:0]    sol_steps;
  logic signed [IW-1:0] sol_inc_x, sol_inc_y;

  assign accept      = start && !busy;
  assign load_acc    = accept && (action_i == ACT_LOAD);
  assign step_acc    = accept && (action_i == ACT_STEP);
  assign line_active = (steps_q != '0);

  // Axis differences of the new line
  assign dx = (COORD_BITS + 1)'(end_x_i) - (COORD_BITS + 1)'(start_x_i);
  assign dy = (COORD_BITS + 1)'(end_y_i) - (COORD_BITS + 1)'(start_y_i);

  lps_solver #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_solver (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (load_acc),
    .dx_i    (dx),
    .dy_i    (dy),
    .steps_o (sol_steps),
    .inc_x_o (sol_inc_x),
    .inc_y_o (sol_inc_y),
    .stat_o  (sol_stat)
  );

  assign busy = sol_stat.busy;

  // Screen bound checks on the current position
  assign ipx = pos_x_q >> FRAC_BITS;
  assign ipy = pos_y_q >> FRAC_BITS;
  assign okx = !pos_x_q[POS_W-1] && (ipx < POS_W'(scr_w_q));
  assign oky = !pos_y_q[POS_W-1] && (ipy < POS_W'(scr_h_q));

  // Line state: load positions on a load request, advance on a step, take the step setup from the solver
  always_comb begin
    pos_x_d = pos_x_q;
    pos_y_d = pos_y_q;
    inc_x_d = inc_x_q;
    inc_y_d = inc_y_q;
    steps_d = steps_q;
    if (load_acc) begin
      pos_x_d = POS_W'(start_x_i) << FRAC_BITS;
      pos_y_d = POS_W'(start_y_i) << FRAC_BITS;
    end else if (step_acc && line_active) begin
      pos_x_d = pos_x_q + POS_W'(inc_x_q);
      pos_y_d = pos_y_q + POS_W'(inc_y_q);
      steps_d = steps_q - 1'b1;
    end
    if (sol_stat.done) begin
      inc_x_d = sol_inc_x;
      inc_y_d = sol_inc_y;
      steps_d = sol_steps;
    end
  end

  // Result register
  always_comb begin
    strobe_d  = 1'b0;
    status_d  = ST_LOADED;
    pix_x_d   = '0;
    pix_y_d   = '0;
    plotted_d = 1'b0;
    last_d    = 1'b0;
    if (sol_stat.done) begin
      strobe_d = 1'b1;
    end else if (step_acc) begin
      strobe_d = 1'b1;
      if (!line_active) begin
        status_d = ST_IDLE;
      end else begin
        status_d = ST_PIXEL;
        last_d   = (steps_q == STEP_W'(1));
        if (okx && oky) begin
          plotted_d = 1'b1;
          pix_x_d   = ipx[PIX_W-1:0];
          pix_y_d   = ipy[PIX_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_w_q   <= SCREEN_W_RST;
      scr_h_q   <= SCREEN_H_RST;
      pos_x_q   <= '0;
      pos_y_q   <= '0;
      inc_x_q   <= '0;
      inc_y_q   <= '0;
      steps_q   <= '0;
      strobe_q  <= 1'b0;
      status_q  <= ST_LOADED;
      pix_x_q   <= '0;
      pix_y_q   <= '0;
      plotted_q <= 1'b0;
      last_q    <= 1'b0;
    end else begin
      // Write configuration
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SCREEN_W: scr_w_q <= cfg_wdata_i;
          CFG_SCREEN_H: scr_h_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
      pos_x_q   <= pos_x_d;
      pos_y_q   <= pos_y_d;
      inc_x_q   <= inc_x_d;
      inc_y_q   <= inc_y_d;
      steps_q   <= steps_d;
      strobe_q  <= strobe_d;
      status_q  <= status_d;
      pix_x_q   <= pix_x_d;
      pix_y_q   <= pix_y_d;
      plotted_q <= plotted_d;
      last_q    <= last_d;
    end
  end

  assign strobe_o  = strobe_q;
  assign status_o  = status_q;
  assign pixel_x_o = pix_x_q;
  assign pixel_y_o = pix_y_q;
  assign plotted_o = plotted_q;
  assign last_o    = last_q;

  `LPS_ASSERT_NEXT(a_load_busy, clk_i, rst_ni, load_acc, busy, "load request did not raise busy")
  `LPS_ASSERT_NEXT(a_load_result, clk_i, rst_ni, sol_stat.done,
                   strobe_o && status_o == ST_LOADED, "solver finish gave no load result")
  `LPS_ASSERT_SAME(a_flags_pixel, clk_i, rst_ni, strobe_o && status_o != ST_PIXEL,
                   !plotted_o && !last_o, "flags set on a non-pixel result")
  `LPS_ASSERT_NEXT(a_steps_down, clk_i, rst_ni, !sol_stat.done,
                   steps_q <= $past(steps_q), "step count rose without a load")

endmodule
